FILE: src/tfre_pkg.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - shared package
// Item types, configuration layout, protocol codes and queue sizing.
// ----------------------------------------------------------------------------
package tfre_pkg;

   // TFTP and flash geometry
   localparam int unsigned TFTP_PORT    = 69;
   localparam int unsigned PAGE_BYTES   = 256;
   localparam int unsigned BLOCK_BYTES  = 2 * PAGE_BYTES;
   localparam int unsigned SECTOR_BYTES = 4096;
   localparam int unsigned SECTOR_LOG2  = $clog2(SECTOR_BYTES);
   localparam int unsigned OP_DATA      = 3;
   localparam int unsigned OP_ERROR     = 5;
   localparam int unsigned STALL_MAX    = 255;
   localparam int unsigned BLOCK_LAST   = 65536;

   // Field widths
   localparam int unsigned IP_W    = 32;
   localparam int unsigned PORT_W  = 16;
   localparam int unsigned BLK_W   = 16;
   localparam int unsigned EXP_W   = 17;
   localparam int unsigned LEN_W   = 10;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned STALL_W = 8;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_A_W = 2;

   // Decoupling queue depth between the front and back parts
   localparam int unsigned QUEUE_DEPTH = 2;

   // Input kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_PACKET = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // Outgoing packet kinds
   localparam logic [1:0] SEND_NONE  = 2'd0;
   localparam logic [1:0] SEND_RRQ   = 2'd1;
   localparam logic [1:0] SEND_ACK   = 2'd2;
   localparam logic [1:0] SEND_ERROR = 2'd3;

   // Session status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_ERROR_RX  = 3'd1;
   localparam logic [2:0] STATUS_BAD_BLOCK = 3'd2;
   localparam logic [2:0] STATUS_BAD_OP    = 3'd3;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_SERVER_IP   = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FLASH_BASE  = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_STALL_LIMIT = 2'd2;

   localparam logic [STALL_W-1:0] STALL_LIMIT_RESET = 8'd10;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_PACKET,
      CMD_TICK,
      CMD_NONE
   } cmd_kind_type;

   typedef enum logic [1:0] {
      OPC_DATA,
      OPC_ERROR,
      OPC_OTHER
   } op_class_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [IP_W-1:0]   src_ip;
      logic [PORT_W-1:0] sender_port;
      logic [15:0]       opcode;
      logic [BLK_W-1:0]  blk_num;
      logic [LEN_W-1:0]  payload_len;
   } req_type;

   typedef struct packed {
      logic [1:0]        send_kind;
      logic [BLK_W-1:0]  ack_block;
      logic [PORT_W-1:0] dest_port;
      logic              write_flash;
      logic              erase_sector;
      logic [ADDR_W-1:0] flash_addr;
      logic              done_res;
      logic [2:0]        status;
      logic              flash_changed;
      logic [ADDR_W-1:0] bytes_written;
   } rsp_type;

   // Classified item as it travels through the queue
   typedef struct packed {
      cmd_kind_type      kind;
      op_class_type      op_class;
      logic              ip_match;
      logic              short_block;
      logic [PORT_W-1:0] sender_port;
      logic [BLK_W-1:0]  blk_num;
      logic [LEN_W-1:0]  data_len;
   } cmd_type;

   typedef struct packed {
      logic [IP_W-1:0]    server_ip;
      logic [ADDR_W-1:0]  flash_base;
      logic [STALL_W-1:0] stall_limit;
   } cfg_type;

endpackage

FILE: src/tfre_front.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - front part
// Classify each request beat: kind, opcode class, sender address match and
// clamped payload length, then hand it to the queue.
// ----------------------------------------------------------------------------
module tfre_front (
   input  tfre_pkg::req_type  req_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  tfre_pkg::cfg_type  cfg,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output tfre_pkg::cmd_type  cmd_data
);

   logic [tfre_pkg::LEN_W-1:0] len_clamped;

   // Pass the handshake straight through to the queue
   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

   // Clamp oversized payloads to one full block
   assign len_clamped = (req_data.payload_len > tfre_pkg::LEN_W'(tfre_pkg::BLOCK_BYTES)) ?
                        tfre_pkg::LEN_W'(tfre_pkg::BLOCK_BYTES) : req_data.payload_len;

   // Build the classified command
   always_comb begin
      cmd_data.sender_port = req_data.sender_port;
      cmd_data.blk_num     = req_data.blk_num;
      cmd_data.data_len    = len_clamped;
      cmd_data.short_block = (len_clamped < tfre_pkg::LEN_W'(tfre_pkg::BLOCK_BYTES));
      cmd_data.ip_match    = (req_data.src_ip == cfg.server_ip);
      case (req_data.kind)
         tfre_pkg::KIND_START:  cmd_data.kind = tfre_pkg::CMD_START;
         tfre_pkg::KIND_PACKET: cmd_data.kind = tfre_pkg::CMD_PACKET;
         tfre_pkg::KIND_TICK:   cmd_data.kind = tfre_pkg::CMD_TICK;
         default:               cmd_data.kind = tfre_pkg::CMD_NONE;
      endcase
      if (req_data.opcode == 16'(tfre_pkg::OP_DATA)) begin
         cmd_data.op_class = tfre_pkg::OPC_DATA;
      end else if (req_data.opcode == 16'(tfre_pkg::OP_ERROR)) begin
         cmd_data.op_class = tfre_pkg::OPC_ERROR;
      end else begin
         cmd_data.op_class = tfre_pkg::OPC_OTHER;
      end
   end

endmodule

FILE: src/tfre_queue.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - command queue
// Small register FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module tfre_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/tfre_back.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - back part
// Hold the session state, carry out each classified command and register
// one response beat per command.
// ----------------------------------------------------------------------------
module tfre_back (
   input  logic               clock,
   input  logic               reset,
   input  tfre_pkg::cfg_type  cfg,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  tfre_pkg::cmd_type  cmd_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tfre_pkg::rsp_type  rsp_data
);

   localparam logic [tfre_pkg::PORT_W-1:0]  TFTP_PORT = tfre_pkg::PORT_W'(tfre_pkg::TFTP_PORT);
   localparam logic [tfre_pkg::STALL_W-1:0] STALL_MAX = tfre_pkg::STALL_W'(tfre_pkg::STALL_MAX);
   localparam logic [tfre_pkg::EXP_W-1:0]   EXP_LAST  = tfre_pkg::EXP_W'(tfre_pkg::BLOCK_LAST);

   // Session state
   logic [tfre_pkg::PORT_W-1:0]  peer_port_ff, peer_port_in;
   logic [tfre_pkg::EXP_W-1:0]   expected_ff, expected_in;
   logic [tfre_pkg::ADDR_W-1:0]  byte_count_ff, byte_count_in;
   logic [tfre_pkg::EXP_W-1:0]   seen_ff, seen_in;
   logic [tfre_pkg::STALL_W-1:0] stall_ff, stall_in;
   logic                         modified_ff, modified_in;
   logic                         active_ff, active_in;

   // Response register
   logic                         rsp_valid_ff, rsp_valid_in;
   tfre_pkg::rsp_type            rsp_data_ff, rsp_in;

   logic                         pop;
   logic [tfre_pkg::ADDR_W-1:0]  addr_cur;
   logic [tfre_pkg::PORT_W-1:0]  peer_latched;
   logic                         sender_ok;
   logic [tfre_pkg::EXP_W-1:0]   blk_ext;
   logic                         done;

   assign cmd_ready = ~rsp_valid_ff | rsp_ready;
   assign pop       = cmd_valid & cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign addr_cur     = cfg.flash_base + byte_count_ff;
   assign peer_latched = (peer_port_ff == TFTP_PORT) ? cmd_data.sender_port : peer_port_ff;
   assign sender_ok    = (peer_latched == cmd_data.sender_port) & cmd_data.ip_match;
   assign blk_ext      = {1'b0, cmd_data.blk_num};

   // Carry out one command against the session state
   always_comb begin
      peer_port_in  = peer_port_ff;
      expected_in   = expected_ff;
      byte_count_in = byte_count_ff;
      seen_in       = seen_ff;
      stall_in      = stall_ff;
      modified_in   = modified_ff;
      active_in     = active_ff;
      done          = 1'b0;

      rsp_in              = '0;
      rsp_in.send_kind    = tfre_pkg::SEND_NONE;
      rsp_in.status       = tfre_pkg::STATUS_OK;
      rsp_in.flash_addr   = addr_cur;

      case (cmd_data.kind)
         tfre_pkg::CMD_START: begin
            peer_port_in      = TFTP_PORT;
            byte_count_in     = '0;
            expected_in       = tfre_pkg::EXP_W'(1);
            seen_in           = '0;
            stall_in          = '0;
            active_in         = 1'b1;
            rsp_in.send_kind  = tfre_pkg::SEND_RRQ;
            rsp_in.flash_addr = cfg.flash_base;
         end
         tfre_pkg::CMD_PACKET: begin
            if (active_ff) begin
               peer_port_in = peer_latched;
               if (sender_ok) begin
                  case (cmd_data.op_class)
                     tfre_pkg::OPC_ERROR: begin
                        rsp_in.status = tfre_pkg::STATUS_ERROR_RX;
                        done          = 1'b1;
                     end
                     tfre_pkg::OPC_DATA: begin
                        if (blk_ext <= expected_ff) begin
                           // Program the next block in order
                           if (blk_ext == expected_ff) begin
                              rsp_in.write_flash  = 1'b1;
                              rsp_in.erase_sector =
                                 (addr_cur[tfre_pkg::SECTOR_LOG2-1:0] == '0);
                              expected_in   = expected_ff + tfre_pkg::EXP_W'(1);
                              modified_in   = 1'b1;
                              byte_count_in = byte_count_ff +
                                              tfre_pkg::ADDR_W'(cmd_data.data_len);
                           end
                           rsp_in.send_kind = tfre_pkg::SEND_ACK;
                           rsp_in.ack_block = cmd_data.blk_num;
                           done             = cmd_data.short_block;
                        end else begin
                           rsp_in.send_kind = tfre_pkg::SEND_ERROR;
                           rsp_in.status    = tfre_pkg::STATUS_BAD_BLOCK;
                           done             = 1'b1;
                        end
                     end
                     default: begin
                        rsp_in.send_kind = tfre_pkg::SEND_ERROR;
                        rsp_in.status    = tfre_pkg::STATUS_BAD_OP;
                        done             = 1'b1;
                     end
                  endcase
               end
            end
         end
         tfre_pkg::CMD_TICK: begin
            if (active_ff) begin
               // Restart the stall count on block progress, else saturate upward
               if (expected_ff > seen_ff) begin
                  seen_in  = expected_ff;
                  stall_in = '0;
               end else if (stall_ff < STALL_MAX) begin
                  stall_in = stall_ff + tfre_pkg::STALL_W'(1);
               end
               if (stall_in >= cfg.stall_limit) begin
                  rsp_in.send_kind = tfre_pkg::SEND_ERROR;
                  rsp_in.status    = tfre_pkg::STATUS_TIMEOUT;
                  done             = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (done) begin
         active_in = 1'b0;
      end
      rsp_in.done_res      = done;
      rsp_in.dest_port     = peer_port_in;
      rsp_in.flash_changed = modified_in;
      rsp_in.bytes_written = byte_count_in;
   end

   // Hold the response until taken, load a new one on pop
   assign rsp_valid_in = pop | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         peer_port_ff  <= TFTP_PORT;
         expected_ff   <= tfre_pkg::EXP_W'(1);
         byte_count_ff <= '0;
         seen_ff       <= '0;
         stall_ff      <= '0;
         modified_ff   <= 1'b0;
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            peer_port_ff  <= peer_port_in;
            expected_ff   <= expected_in;
            byte_count_ff <= byte_count_in;
            seen_ff       <= seen_in;
            stall_ff      <= stall_in;
            modified_ff   <= modified_in;
            active_ff     <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Block counter never passes the rollover limit
   a_expected_bound: assert property (@(posedge clock) disable iff (reset)
      expected_ff <= EXP_LAST)
      else $error("expected block beyond rollover limit");

   // A failure status always ends the session
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != tfre_pkg::STATUS_OK) |-> rsp_data_ff.done_res)
      else $error("failure status without session end");

   // Programming goes with an acknowledge and marks flash as changed
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.write_flash |->
         (rsp_data_ff.send_kind == tfre_pkg::SEND_ACK) && rsp_data_ff.flash_changed)
      else $error("flash write without ack");

   // A finished session stays closed until the next command
   a_done_closes: assert property (@(posedge clock) disable iff (reset)
      pop && done |=> !active_ff)
      else $error("session still active after end");

endmodule

FILE: src/tftp_receive_flash_engine_core.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - top level
// Client side of a TFTP read transfer that streams the image into flash.
// ----------------------------------------------------------------------------
// The block returns exactly one response beat per request, in order. A request
// is classified in the front part in the cycle it is accepted, waits in a
// small command queue, and is carried out by the back part, whose session
// update (one 32-bit add for the flash address, one for the byte count, and
// short compares) sets the sustained rate of one request beat per clock while
// responses are taken. A request passes the queue slot and response registers
// in turn; response backpressure fills the queue before request ready drops.
// The user must write configuration registers through the csr_ port only
// while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module tftp_receive_flash_engine_core #(
   parameter int unsigned QUEUE_DEPTH = tfre_pkg::QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tfre_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tfre_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [tfre_pkg::CSR_A_W-1:0]   csr_addr,
   input  logic [tfre_pkg::CSR_W-1:0]     csr_wdata
);

   tfre_pkg::cfg_type cfg_ff, cfg_in;
   tfre_pkg::cmd_type push_cmd, pop_cmd;
   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            tfre_pkg::CSR_SERVER_IP:   cfg_in.server_ip   = csr_wdata;
            tfre_pkg::CSR_FLASH_BASE:  cfg_in.flash_base  = csr_wdata;
            tfre_pkg::CSR_STALL_LIMIT: cfg_in.stall_limit = csr_wdata[tfre_pkg::STALL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_ip   <= '0;
         cfg_ff.flash_base  <= '0;
         cfg_ff.stall_limit <= tfre_pkg::STALL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tfre_front u_front (
      .req_data  (req_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cfg       (cfg_ff),
      .cmd_valid (push_valid),
      .cmd_ready (push_ready),
      .cmd_data  (push_cmd)
   );

   tfre_queue #(
      .WIDTH ($bits(tfre_pkg::cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_cmd)
   );

   tfre_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd_data  (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/tfre_transfer_check.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - transfer checker
// Watches the request, response and register ports, tracks the TFTP session
// in its own copy of the engine state and compares every response beat
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tfre_transfer_check (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  tfre_pkg::req_type            req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  tfre_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [tfre_pkg::CSR_A_W-1:0] csr_addr,
   input  logic [tfre_pkg::CSR_W-1:0]   csr_wdata,
   output int                           mismatches,
   output int                           pending
);

   localparam logic [tfre_pkg::LEN_W-1:0]   FULL_LEN  = tfre_pkg::LEN_W'(tfre_pkg::BLOCK_BYTES);
   localparam logic [tfre_pkg::PORT_W-1:0]  WK_PORT   = tfre_pkg::PORT_W'(tfre_pkg::TFTP_PORT);
   localparam logic [15:0]                  OPC_DATA  = 16'(tfre_pkg::OP_DATA);
   localparam logic [15:0]                  OPC_ERROR = 16'(tfre_pkg::OP_ERROR);
   localparam logic [tfre_pkg::STALL_W-1:0] STALL_TOP = tfre_pkg::STALL_W'(tfre_pkg::STALL_MAX);
   localparam logic [tfre_pkg::EXP_W-1:0]   BLOCK_ONE = tfre_pkg::EXP_W'(1);

   // Register copies
   logic [tfre_pkg::IP_W-1:0]    server_ip_r;
   logic [tfre_pkg::ADDR_W-1:0]  flash_base_r;
   logic [tfre_pkg::STALL_W-1:0] stall_limit_r;

   // Session state
   logic [tfre_pkg::PORT_W-1:0]  peer_port;
   logic [tfre_pkg::EXP_W-1:0]   next_block;
   logic [tfre_pkg::ADDR_W-1:0]  image_bytes;
   logic [tfre_pkg::EXP_W-1:0]   progress_mark;
   logic [tfre_pkg::STALL_W-1:0] stall_ticks;
   logic                         flash_dirty;
   logic                         in_session;

   tfre_pkg::rsp_type            outcome_q[$];
   int                           fail_count = 0;
   int                           in_flight = 0;

   assign mismatches = fail_count;
   assign pending    = in_flight;

   // Advance the session by one request beat and build the response it causes
   task automatic advance_session(input tfre_pkg::req_type beat,
                                  output tfre_pkg::rsp_type res);
      logic [tfre_pkg::LEN_W-1:0]  len;
      logic [tfre_pkg::ADDR_W-1:0] addr;
      res  = '0;
      len  = beat.payload_len;
      if (beat.payload_len > FULL_LEN)
         len = FULL_LEN;
      addr = flash_base_r + image_bytes;
      case (beat.kind)
         tfre_pkg::KIND_START: begin
            peer_port     = WK_PORT;
            image_bytes   = '0;
            next_block    = BLOCK_ONE;
            progress_mark = '0;
            stall_ticks   = '0;
            in_session    = 1'b1;
            res.send_kind = tfre_pkg::SEND_RRQ;
            addr          = flash_base_r;
         end
         tfre_pkg::KIND_PACKET: begin
            if (in_session) begin
               // first reply from the server fixes its port
               if (peer_port == WK_PORT)
                  peer_port = beat.sender_port;
               if (peer_port == beat.sender_port && beat.src_ip == server_ip_r) begin
                  if (beat.opcode == OPC_ERROR) begin
                     res.status   = tfre_pkg::STATUS_ERROR_RX;
                     res.done_res = 1'b1;
                  end else if (beat.opcode == OPC_DATA) begin
                     if ({1'b0, beat.blk_num} <= next_block) begin
                        if ({1'b0, beat.blk_num} == next_block) begin
                           res.write_flash  = 1'b1;
                           res.erase_sector = (addr[tfre_pkg::SECTOR_LOG2-1:0] == '0);
                           next_block       = next_block + BLOCK_ONE;
                           flash_dirty      = 1'b1;
                           image_bytes      = image_bytes + tfre_pkg::ADDR_W'(len);
                        end
                        res.send_kind = tfre_pkg::SEND_ACK;
                        res.ack_block = beat.blk_num;
                        if (len < FULL_LEN)
                           res.done_res = 1'b1;
                     end else begin
                        res.send_kind = tfre_pkg::SEND_ERROR;
                        res.status    = tfre_pkg::STATUS_BAD_BLOCK;
                        res.done_res  = 1'b1;
                     end
                  end else begin
                     res.send_kind = tfre_pkg::SEND_ERROR;
                     res.status    = tfre_pkg::STATUS_BAD_OP;
                     res.done_res  = 1'b1;
                  end
               end
            end
         end
         tfre_pkg::KIND_TICK: begin
            if (in_session) begin
               if (next_block > progress_mark) begin
                  progress_mark = next_block;
                  stall_ticks   = '0;
               end else if (stall_ticks < STALL_TOP) begin
                  stall_ticks = stall_ticks + tfre_pkg::STALL_W'(1);
               end
               if (stall_ticks >= stall_limit_r) begin
                  res.send_kind = tfre_pkg::SEND_ERROR;
                  res.status    = tfre_pkg::STATUS_TIMEOUT;
                  res.done_res  = 1'b1;
               end
            end
         end
         default: ;
      endcase
      if (res.done_res)
         in_session = 1'b0;
      res.dest_port     = peer_port;
      res.flash_addr    = addr;
      res.flash_changed = flash_dirty;
      res.bytes_written = image_bytes;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // Sample all ports at the edge; predict on request beats, compare on response beats
   always @(posedge clock) begin : watch
      tfre_pkg::rsp_type want;
      tfre_pkg::rsp_type got;
      if (reset) begin
         server_ip_r   = '0;
         flash_base_r  = '0;
         stall_limit_r = tfre_pkg::STALL_LIMIT_RESET;
         peer_port     = WK_PORT;
         next_block    = BLOCK_ONE;
         image_bytes   = '0;
         progress_mark = '0;
         stall_ticks   = '0;
         flash_dirty   = 1'b0;
         in_session    = 1'b0;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               tfre_pkg::CSR_SERVER_IP:   server_ip_r   = csr_wdata;
               tfre_pkg::CSR_FLASH_BASE:  flash_base_r  = csr_wdata;
               tfre_pkg::CSR_STALL_LIMIT: stall_limit_r = csr_wdata[tfre_pkg::STALL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_session(req_data, want);
            outcome_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            if (outcome_q.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("send_kind", 32'(want.send_kind), 32'(got.send_kind));
               check_field("ack_block", 32'(want.ack_block), 32'(got.ack_block));
               check_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
               check_field("write_flash", 32'(want.write_flash), 32'(got.write_flash));
               check_field("erase_sector", 32'(want.erase_sector), 32'(got.erase_sector));
               check_field("flash_addr", want.flash_addr, got.flash_addr);
               check_field("done_res", 32'(want.done_res), 32'(got.done_res));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("flash_changed", 32'(want.flash_changed),
                           32'(got.flash_changed));
               check_field("bytes_written", want.bytes_written, got.bytes_written);
            end
         end
      end
      in_flight <= outcome_q.size();
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// TFTP receive flash engine - testbench top
// Drives directed and random TFTP read sessions into the engine under
// several register settings, with random idling on both channels and one
// long response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam logic [1:0]                   KIND_SPARE  = 2'd3;
   localparam logic [tfre_pkg::CSR_A_W-1:0] CSR_SPARE   = 2'd3;
   localparam logic [31:0]                  FIRST_IP    = 32'hFFFF_FFFF;
   localparam logic [31:0]                  FULL_LEN    = 32'(tfre_pkg::BLOCK_BYTES);
   localparam logic [31:0]                  WK_PORT     = 32'(tfre_pkg::TFTP_PORT);
   localparam logic [31:0]                  OPC_DATA    = 32'(tfre_pkg::OP_DATA);
   localparam logic [31:0]                  OPC_ERROR   = 32'(tfre_pkg::OP_ERROR);
   localparam int                           HOLD_CYCLES = 300;
   localparam int                           CYCLE_LIMIT = 600000;
   localparam int                           PHASES      = 6;
   localparam int                           PHASE_BEATS = 175;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   tfre_pkg::req_type            req_data  = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   tfre_pkg::rsp_type            rsp_data;
   logic                         csr_we    = 1'b0;
   logic [tfre_pkg::CSR_A_W-1:0] csr_addr  = '0;
   logic [tfre_pkg::CSR_W-1:0]   csr_wdata = '0;

   int                 mismatches;
   int                 pending;
   int                 beats_sent   = 0;
   int                 idle_odds    = 0;
   int                 stall_cfg    = 10;
   int                 cycle_count  = 0;
   bit                 hold_request = 1'b0;

   always #5 clock = ~clock;

   tftp_receive_flash_engine_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   tfre_transfer_check transfer_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Response side: random stall bursts, plus one long hold-off on request
   initial begin : response_side
      bit hold_done;
      hold_done = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic tfre_pkg::req_type beat_of(input logic [1:0] kind,
                                                 input logic [31:0] ip,
                                                 input logic [31:0] port,
                                                 input logic [31:0] op,
                                                 input logic [31:0] blk,
                                                 input logic [31:0] len);
      tfre_pkg::req_type b;
      b.kind        = kind;
      b.src_ip      = ip;
      b.sender_port = port[tfre_pkg::PORT_W-1:0];
      b.opcode      = op[15:0];
      b.blk_num     = blk[tfre_pkg::BLK_W-1:0];
      b.payload_len = len[tfre_pkg::LEN_W-1:0];
      return b;
   endfunction

   function automatic tfre_pkg::req_type noise_beat();
      return beat_of(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                     $urandom);
   endfunction

   function automatic logic [31:0] full_len();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(tfre_pkg::BLOCK_BYTES + 1, 1023);
      return FULL_LEN;
   endfunction

   // Offer one beat, hold it until taken, then maybe idle
   task automatic send_item(input tfre_pkg::req_type b);
      req_data  <= b;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [tfre_pkg::CSR_A_W-1:0] idx,
                            input logic [tfre_pkg::CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Stop offering and wait out every outstanding response
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_stall_limit(input logic [7:0] limit);
      logic [23:0] junk;
      junk      = 24'($urandom);
      stall_cfg = int'(limit);
      write_reg(tfre_pkg::CSR_STALL_LIMIT, {junk, limit});
   endtask

   // One well-formed session with random content, noise, and a random ending
   task automatic run_session(input logic [31:0] ip, input int blocks);
      logic [31:0] port;
      logic [31:0] op;
      int          b;
      port = $urandom;
      if ($urandom_range(0, 7) == 0)
         port = WK_PORT;
      send_item(beat_of(tfre_pkg::KIND_START, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
      for (b = 1; b <= blocks; b++) begin
         case ($urandom_range(0, 15))
            0: send_item(noise_beat());
            1: send_item(beat_of(tfre_pkg::KIND_TICK, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
            2: send_item(beat_of(tfre_pkg::KIND_PACKET, ip ^ (32'd1 << $urandom_range(0, 31)),
                                 port, OPC_DATA, b, FULL_LEN));
            3: send_item(beat_of(tfre_pkg::KIND_PACKET, ip,
                                 port ^ (32'd1 << $urandom_range(0, 15)),
                                 OPC_DATA, b, FULL_LEN));
            4: send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, OPC_DATA, b - 1,
                                 full_len()));
            default: ;
         endcase
         send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, OPC_DATA, b, full_len()));
      end
      case ($urandom_range(0, 5))
         0, 1: send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, OPC_DATA, blocks + 1,
                                 $urandom_range(0, tfre_pkg::BLOCK_BYTES - 1)));
         2: send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, OPC_ERROR, $urandom,
                              $urandom));
         3: send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, OPC_DATA,
                              blocks + 1 + $urandom_range(1, 1000), full_len()));
         4: begin
            op = $urandom_range(tfre_pkg::OP_ERROR + 1, 65535);
            if ($urandom_range(0, 1) == 1)
               op = $urandom_range(0, tfre_pkg::OP_DATA - 1);
            send_item(beat_of(tfre_pkg::KIND_PACKET, ip, port, op, blocks + 1, full_len()));
         end
         default: begin
            // stall it out where the limit is short, else leave it for a restart
            if (stall_cfg <= 20)
               repeat (stall_cfg + 2)
                  send_item(beat_of(tfre_pkg::KIND_TICK, $urandom, $urandom, $urandom,
                                    $urandom, $urandom));
         end
      endcase
   endtask

   initial begin : stimulus
      logic [31:0] ip;
      logic [31:0] base;
      int          p;
      int          phase_end;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: idle, latch, drop, timeout, every ending, restart
      write_reg(tfre_pkg::CSR_SERVER_IP, FIRST_IP);
      write_reg(tfre_pkg::CSR_FLASH_BASE, 32'hFFFF_FE00);
      set_stall_limit(8'd2);
      send_item(beat_of(tfre_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'hFFFF, OPC_DATA, 1, FULL_LEN));
      send_item(beat_of(KIND_SPARE, '1, '1, '1, '1, '1));
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, WK_PORT, OPC_DATA, 1, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h1234, OPC_DATA, 2, 32'h3FF));
      send_item(beat_of(tfre_pkg::KIND_PACKET, 32'h0, 32'h1234, OPC_DATA, 3, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'hFFFF, OPC_DATA, 3, FULL_LEN));
      repeat (3) send_item(beat_of(tfre_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_START, '1, '1, '1, '1, '1));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h0000, OPC_DATA, 1, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h0000, OPC_DATA, 0, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h0000, OPC_DATA, 32'hFFFF,
                        FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'hFFFF, 32'hFFFF, 1, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h8000, OPC_ERROR, 1, 0));
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h0007, OPC_DATA, 1, FULL_LEN));
      send_item(beat_of(tfre_pkg::KIND_PACKET, FIRST_IP, 32'h0007, OPC_DATA, 1, 0));
      settle();

      // Zero stall limit: first tick times out
      set_stall_limit(8'd0);
      write_reg(CSR_SPARE, $urandom);
      send_item(beat_of(tfre_pkg::KIND_START, 0, 0, 0, 0, 0));
      send_item(beat_of(tfre_pkg::KIND_TICK, 0, 0, 0, 0, 0));
      settle();

      // Random sessions under a spread of register settings
      for (p = 0; p < PHASES; p++) begin
         ip = $urandom;
         if (p == 0)
            ip = '0;
         else if (p == 1)
            ip = '1;
         case (p % 4)
            0: base = '0;
            1: base = 32'hFFFF_F000;
            2: base = $urandom;
            default: base = $urandom & ~32'hFFF;
         endcase
         write_reg(tfre_pkg::CSR_SERVER_IP, ip);
         write_reg(tfre_pkg::CSR_FLASH_BASE, base);
         case (p)
            0: set_stall_limit(8'd255);
            1: set_stall_limit(8'd1);
            3: set_stall_limit(8'd3);
            4: set_stall_limit(8'($urandom_range(1, 20)));
            default: set_stall_limit(8'($urandom_range(1, 255)));
         endcase
         case (p)
            0: idle_odds = 2;
            1: idle_odds = 4;
            2: idle_odds = 3;
            3: idle_odds = 0;
            4: idle_odds = 6;
            default: idle_odds = 0;
         endcase
         // long response hold-off while requests keep coming
         if (p == 2)
            hold_request = 1'b1;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end)
            run_session(ip, $urandom_range(1, 24));
         settle();
      end
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: sim.f
src/tfre_pkg.sv
src/tfre_front.sv
src/tfre_queue.sv
src/tfre_back.sv
src/tftp_receive_flash_engine_core.sv
tb/sv/tfre_transfer_check.sv
tb/sv/tb.sv
